/* src/mouse_pan_zoom_view_control_assert.svh */
// Assertion macros shared by the mouse pan and zoom view control RTL.
// No dependencies; included by the modules that carry concurrent checks.
`ifndef MOUSE_PAN_ZOOM_VIEW_CONTROL_ASSERT_SVH
`define MOUSE_PAN_ZOOM_VIEW_CONTROL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPZ_ASSERT_IMP(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MPZ_ASSERT_NXT(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/mpz_pkg.sv */
// Package for the mouse pan and zoom view control: widths, register indexes,
// shared types and the Q4.40 to Q8.23 conversion. No dependencies.
`default_nettype none

package mpz_pkg;

    // View size in pixels
    localparam int VIEW_WIDTH  = 640;
    localparam int VIEW_HEIGHT = 480;
    localparam int VIEW_MAX    = (VIEW_WIDTH > VIEW_HEIGHT) ? VIEW_WIDTH : VIEW_HEIGHT;
    localparam int VIEW_BITS   = $clog2(VIEW_MAX + 1);

    // Field and register widths
    localparam int BYTE_W      = 8;
    localparam int STEP_W      = 20;
    localparam int ZOOM_W      = 5;
    localparam int LIMIT_W     = 26;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 26;
    localparam int MOTION_W    = 9;
    localparam int CORNER_W    = 32;

    // Fixed-point shifts: Q4.40 centre, Q8.23 outputs, steps in units of 2^-23
    localparam int FRAC_DROP   = 17;
    localparam int PAN_SHIFT   = 18;
    localparam int HALF_SHIFT  = 16;

    // Centre state and pan arithmetic
    localparam int CENTER_W    = 45;
    localparam int PAN2_W      = STEP_W + PAN_SHIFT;
    localparam int PROD_W      = MOTION_W + PAN2_W + 1;
    localparam int CSUM_W      = PROD_W + 1;

    // Half view extent and corner sums
    localparam int VPROD_W     = STEP_W + VIEW_BITS;
    localparam int HALF_W      = VPROD_W + HALF_SHIFT;
    localparam int SUM_W       = ((HALF_W > CENTER_W) ? HALF_W : CENTER_W) + 1;
    localparam int Q_W         = (SUM_W > CORNER_W + 1) ? SUM_W : CORNER_W + 1;

    // Reset values
    localparam logic [STEP_W-1:0]      STEP_RST         = STEP_W'(39000);
    localparam logic [ZOOM_W-1:0]      MAX_ZOOM_RST     = ZOOM_W'(16);
    localparam logic [LIMIT_W-1:0]     CENTER_LIMIT_RST = LIMIT_W'(58720256);
    localparam logic signed [CENTER_W-1:0] CENTER_RE_RST =
        -(CENTER_W'(1) <<< 39);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ZOOM     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_LIMIT = CFG_IDX_W'(2);

    // Status byte bit positions
    localparam int ST_LEFT    = 0;
    localparam int ST_RIGHT   = 1;
    localparam int ST_MIDDLE  = 2;
    localparam int ST_X_SIGN  = 4;
    localparam int ST_Y_SIGN  = 5;

    typedef struct packed {
        logic [ZOOM_W-1:0] level;
        logic              changed;
    } zoom_info_t;

    typedef struct packed {
        logic                       middle;
        logic signed [MOTION_W-1:0] mx;
        logic signed [MOTION_W-1:0] my;
    } pan_req_t;

    // Q4.40 to Q8.23, truncating toward zero and saturating to 32 bits.
    function automatic logic signed [CORNER_W-1:0] to_q23(input logic signed [SUM_W-1:0] v);
        logic signed [Q_W-1:0] wide;
        logic signed [Q_W-1:0] q;
        logic signed [Q_W-1:0] q_max;
        logic signed [Q_W-1:0] q_min;
        wide  = Q_W'(v);
        q_max = Q_W'((64'sd1 <<< (CORNER_W - 1)) - 64'sd1);
        q_min = -q_max - Q_W'(1);
        if (wide[Q_W-1])
        begin
            wide = wide + Q_W'((64'd1 << FRAC_DROP) - 64'd1);
        end
        q = wide >>> FRAC_DROP;
        if (q > q_max)
        begin
            q = q_max;
        end
        else if (q < q_min)
        begin
            q = q_min;
        end
        return q[CORNER_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/mpz_zoom.sv */
// Zoom level tracker: button press edge detection and saturating zoom steps.
// Depends on mpz_pkg and the assertion macro header.
`default_nettype none
`include "mouse_pan_zoom_view_control_assert.svh"

module mpz_zoom import mpz_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              left,
    input  wire logic              right,
    input  wire logic [ZOOM_W-1:0] max_zoom,
    output zoom_info_t             zinfo
);

    logic [ZOOM_W-1:0] zoom_level_reg, zoom_level_next;
    logic              last_left_reg, last_left_next;
    logic              last_right_reg, last_right_next;
    logic [ZOOM_W-1:0] after_up;
    logic              step_up;
    logic              step_down;

    // Left edge is applied before right edge.
    always_comb
    begin
        step_up   = left && !last_left_reg && (zoom_level_reg < max_zoom);
        after_up  = step_up ? zoom_level_reg + ZOOM_W'(1) : zoom_level_reg;
        step_down = right && !last_right_reg && (after_up != '0);
        zinfo.level   = step_down ? after_up - ZOOM_W'(1) : after_up;
        zinfo.changed = step_up || step_down;
    end

    always_comb
    begin
        zoom_level_next = zoom_level_reg;
        last_left_next  = last_left_reg;
        last_right_next = last_right_reg;
        if (advance)
        begin
            zoom_level_next = zinfo.level;
            last_left_next  = left;
            last_right_next = right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_level_reg <= '0;
            last_left_reg  <= 1'b0;
            last_right_reg <= 1'b0;
        end
        else
        begin
            zoom_level_reg <= zoom_level_next;
            last_left_reg  <= last_left_next;
            last_right_reg <= last_right_next;
        end
    end

    `MPZ_ASSERT_IMP(a_zoom_move_flagged, clk, rst_n, advance && (zinfo.level != zoom_level_reg), zinfo.changed, "zoom moved without change flag")
    `MPZ_ASSERT_NXT(a_zoom_idle_hold, clk, rst_n, !advance, $stable(zoom_level_reg), "zoom moved with no word in work")

endmodule

`default_nettype wire

/* src/mpz_center.sv */
// View centre state in Q4.40: pan by motion times twice the step over 2^zoom, then clamp.
// Depends on mpz_pkg and the assertion macro header.
`default_nettype none
`include "mouse_pan_zoom_view_control_assert.svh"

module mpz_center import mpz_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire pan_req_t                   pan,
    input  wire logic [ZOOM_W-1:0]          zoom,
    input  wire logic [STEP_W-1:0]          pixel_step,
    input  wire logic [LIMIT_W-1:0]         center_limit,
    output logic signed [CENTER_W-1:0]      center_re_now,
    output logic signed [CENTER_W-1:0]      center_im_now
);

    logic signed [CENTER_W-1:0] center_re_reg, center_re_next;
    logic signed [CENTER_W-1:0] center_im_reg, center_im_next;
    logic [PAN2_W-1:0]          pan2;
    logic signed [PAN2_W:0]     pan2_s;
    logic signed [PROD_W-1:0]   prod_re;
    logic signed [PROD_W-1:0]   prod_im;
    logic signed [CSUM_W-1:0]   sum_re;
    logic signed [CSUM_W-1:0]   sum_im;
    logic signed [CSUM_W-1:0]   lim;
    logic signed [CSUM_W-1:0]   clamp_re;
    logic signed [CSUM_W-1:0]   clamp_im;

    always_comb
    begin
        pan2    = {pixel_step, {PAN_SHIFT{1'b0}}} >> zoom;
        pan2_s  = $signed({1'b0, pan2});
        prod_re = PROD_W'(pan.mx) * PROD_W'(pan2_s);
        prod_im = PROD_W'(pan.my) * PROD_W'(pan2_s);
        sum_re  = CSUM_W'(center_re_reg) + CSUM_W'(prod_re);
        sum_im  = CSUM_W'(center_im_reg) - CSUM_W'(prod_im);
        lim     = $signed(CSUM_W'({center_limit, {FRAC_DROP{1'b0}}}));

        priority if (sum_re > lim)
            clamp_re = lim;
        else if (sum_re < -lim)
            clamp_re = -lim;
        else
            clamp_re = sum_re;

        priority if (sum_im > lim)
            clamp_im = lim;
        else if (sum_im < -lim)
            clamp_im = -lim;
        else
            clamp_im = sum_im;

        // The centre only moves, and is only clamped, while middle is held.
        if (pan.middle)
        begin
            center_re_now = clamp_re[CENTER_W-1:0];
            center_im_now = clamp_im[CENTER_W-1:0];
        end
        else
        begin
            center_re_now = center_re_reg;
            center_im_now = center_im_reg;
        end

        center_re_next = advance ? center_re_now : center_re_reg;
        center_im_next = advance ? center_im_now : center_im_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_re_reg <= CENTER_RE_RST;
            center_im_reg <= '0;
        end
        else
        begin
            center_re_reg <= center_re_next;
            center_im_reg <= center_im_next;
        end
    end

    `MPZ_ASSERT_NXT(a_pan_re_in_bounds, clk, rst_n, advance && pan.middle, (CSUM_W'(center_re_reg) <= $past(lim)) && (CSUM_W'(center_re_reg) >= -$past(lim)), "real centre outside clamp after pan")
    `MPZ_ASSERT_NXT(a_pan_im_in_bounds, clk, rst_n, advance && pan.middle, (CSUM_W'(center_im_reg) <= $past(lim)) && (CSUM_W'(center_im_reg) >= -$past(lim)), "imaginary centre outside clamp after pan")

endmodule

`default_nettype wire

/* src/mpz_corner.sv */
// Top-left corner of the view: centre minus half width, plus half height,
// converted to Q8.23. Depends on mpz_pkg.
`default_nettype none

module mpz_corner import mpz_pkg::*;
(
    input  wire logic signed [CENTER_W-1:0] center_re,
    input  wire logic signed [CENTER_W-1:0] center_im,
    input  wire logic [ZOOM_W-1:0]          zoom,
    input  wire logic [STEP_W-1:0]          pixel_step,
    output logic signed [CORNER_W-1:0]      corner_re,
    output logic signed [CORNER_W-1:0]      corner_im
);

    logic [VPROD_W-1:0]      w_prod;
    logic [VPROD_W-1:0]      h_prod;
    logic [HALF_W-1:0]       half_w;
    logic [HALF_W-1:0]       half_h;
    logic signed [SUM_W-1:0] edge_re;
    logic signed [SUM_W-1:0] edge_im;

    always_comb
    begin
        w_prod  = VPROD_W'(VIEW_WIDTH) * VPROD_W'(pixel_step);
        h_prod  = VPROD_W'(VIEW_HEIGHT) * VPROD_W'(pixel_step);
        half_w  = {w_prod, {HALF_SHIFT{1'b0}}} >> zoom;
        half_h  = {h_prod, {HALF_SHIFT{1'b0}}} >> zoom;
        edge_re = SUM_W'(center_re) - $signed(SUM_W'(half_w));
        edge_im = SUM_W'(center_im) + $signed(SUM_W'(half_h));
        corner_re = to_q23(edge_re);
        corner_im = to_q23(edge_im);
    end

endmodule

`default_nettype wire

/* src/mouse_pan_zoom_view_control.sv */
// Top level of the mouse pan and zoom view control: stream ports, register
// file, input and result registers. Depends on mpz_pkg, mpz_zoom, mpz_center,
// mpz_corner and the assertion macro header.
`default_nettype none
`include "mouse_pan_zoom_view_control_assert.svh"

// Takes one raw three-byte mouse packet per word and returns one word per
// packet: the zoom level, the top-left corner of the view in Q8.23 and a
// flag that is set when the zoom moved or a pan was applied. A packet is
// held in an input register, worked through combinationally (zoom step,
// pan multiply, clamp and corner conversion) and written into a result
// register, from which it is offered; one packet per cycle is sustained
// while m_tready is high, as the input register reloads in the same cycle
// that its packet moves into the result register. The zoom level, button
// history and centre are updated as each packet passes into the result
// register, so every packet sees the state left by the one before it.
// Configuration registers take effect at once and must only be written
// while no packet is in flight.
module mouse_pan_zoom_view_control import mpz_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Packet stream in
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata: status_byte [7:0], dx_byte [15:8], dy_byte [23:16]
    input  wire logic [23:0]           s_tdata,
    // View stream out
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata: zoom_now [4:0], corner_re [36:5], corner_im [68:37], zeros above
    output logic [71:0]                m_tdata,
    // m_tuser: view_changed [0]
    output logic                       m_tuser
);

    // Configuration registers
    logic [STEP_W-1:0]      pixel_step_reg, pixel_step_next;
    logic [ZOOM_W-1:0]      max_zoom_reg, max_zoom_next;
    logic [LIMIT_W-1:0]     center_limit_reg, center_limit_next;

    // Input register
    logic                   in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]      status_reg, status_next;
    logic [BYTE_W-1:0]      dx_reg, dx_next;
    logic [BYTE_W-1:0]      dy_reg, dy_next;

    // Result register
    logic                       out_valid_reg, out_valid_next;
    logic [ZOOM_W-1:0]          zoom_out_reg, zoom_out_next;
    logic signed [CORNER_W-1:0] corner_re_reg, corner_re_next;
    logic signed [CORNER_W-1:0] corner_im_reg, corner_im_next;
    logic                       changed_reg, changed_next;

    logic                       in_take;
    logic                       advance;
    zoom_info_t                 zinfo;
    pan_req_t                   pan;
    logic signed [CENTER_W-1:0] center_re_now;
    logic signed [CENTER_W-1:0] center_im_now;
    logic signed [CORNER_W-1:0] corner_re;
    logic signed [CORNER_W-1:0] corner_im;

    // The packet moves on whenever the result register is empty or being read.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        pixel_step_next   = pixel_step_reg;
        max_zoom_next     = max_zoom_reg;
        center_limit_next = center_limit_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PIXEL_STEP:   pixel_step_next   = cfg_data[STEP_W-1:0];
                CFG_MAX_ZOOM:     max_zoom_next     = cfg_data[ZOOM_W-1:0];
                CFG_CENTER_LIMIT: center_limit_next = cfg_data[LIMIT_W-1:0];
                default:          ; // unknown index: write is dropped
            endcase
        end
    end

    always_comb
    begin
        status_next   = status_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            status_next   = s_tdata[7:0];
            dx_next       = s_tdata[15:8];
            dy_next       = s_tdata[23:16];
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Motions are nine-bit two's complement with the sign in the status byte.
    always_comb
    begin
        pan.middle = status_reg[ST_MIDDLE];
        pan.mx     = $signed({status_reg[ST_X_SIGN], dx_reg});
        pan.my     = $signed({status_reg[ST_Y_SIGN], dy_reg});
    end

    mpz_zoom u_zoom (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .left     (status_reg[ST_LEFT]),
        .right    (status_reg[ST_RIGHT]),
        .max_zoom (max_zoom_reg),
        .zinfo    (zinfo)
    );

    mpz_center u_center (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .pan           (pan),
        .zoom          (zinfo.level),
        .pixel_step    (pixel_step_reg),
        .center_limit  (center_limit_reg),
        .center_re_now (center_re_now),
        .center_im_now (center_im_now)
    );

    mpz_corner u_corner (
        .center_re  (center_re_now),
        .center_im  (center_im_now),
        .zoom       (zinfo.level),
        .pixel_step (pixel_step_reg),
        .corner_re  (corner_re),
        .corner_im  (corner_im)
    );

    always_comb
    begin
        zoom_out_next  = zoom_out_reg;
        corner_re_next = corner_re_reg;
        corner_im_next = corner_im_reg;
        changed_next   = changed_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            zoom_out_next  = zinfo.level;
            corner_re_next = corner_re;
            corner_im_next = corner_im;
            // A held middle button counts as a change even with zero motion.
            changed_next   = zinfo.changed || pan.middle;
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_step_reg   <= STEP_RST;
            max_zoom_reg     <= MAX_ZOOM_RST;
            center_limit_reg <= CENTER_LIMIT_RST;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            pixel_step_reg   <= pixel_step_next;
            max_zoom_reg     <= max_zoom_next;
            center_limit_reg <= center_limit_next;
            in_valid_reg     <= in_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        zoom_out_reg  <= zoom_out_next;
        corner_re_reg <= corner_re_next;
        corner_im_reg <= corner_im_next;
        changed_reg   <= changed_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, corner_im_reg, corner_re_reg, zoom_out_reg};
    assign m_tuser  = changed_reg;

    `MPZ_ASSERT_NXT(a_result_follows, clk, rst_n, advance, out_valid_reg && (zoom_out_reg == $past(zinfo.level)), "packet in work did not reach the result register")
    `MPZ_ASSERT_IMP(a_middle_flags_change, clk, rst_n, advance && pan.middle, changed_next, "pan applied without change flag")

endmodule

`default_nettype wire
